// ----- design/spi_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_pkg
// shared types, widths, status codes and the exp2 constant table
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int IN_W      = 24;             // input magnitude width
    localparam int OFF_FRAC  = 15;             // fraction bits of the bin offset
    localparam int OFF_W     = OFF_FRAC + 1;   // bin offset width
    localparam int AMP_W     = IN_W + 1;       // amplitude width
    localparam int LOG_FRAC  = 16;             // fraction bits of log2 values
    localparam int LOG_W     = 5 + LOG_FRAC;   // log2 of an IN_W value
    localparam int MANT_W    = 31;             // Q1.30 mantissa (value below 2)
    localparam int Q30       = 30;
    localparam int VAL_W     = IN_W + 2;       // signed domain value / numerator
    localparam int DEN_W     = IN_W + 3;       // signed curvature
    localparam int DVD_W     = IN_W + 17;      // dividend of the offset division
    localparam int DVS_W     = IN_W + 3;       // divisor (twice the curvature)
    localparam int QUO_W     = OFF_FRAC + 2;   // quotient bits before clamping
    localparam int PROD_W    = VAL_W + OFF_W;  // numerator times offset
    localparam int Y_W       = IN_W + 4;       // adjusted peak value
    localparam int EXP_N_W   = Y_W - LOG_FRAC; // integer part of a log value

    localparam int LOG_LAT   = LOG_FRAC + 1;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int EXP_STEPS = LOG_FRAC;
    localparam int PIPE_LAT  = LOG_LAT + DIV_LAT + EXP_STEPS + 6;

    localparam logic [AMP_W-1:0] AMP_MAX = {AMP_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_CURV = 2'd1,
        ST_ZERO_IN   = 2'd2,
        ST_SAT       = 2'd3
    } t_status;

    // side information carried through the divider
    typedef struct packed {
        logic [IN_W-1:0]         pk;
        logic signed [VAL_W-1:0] b;
        logic signed [VAL_W-1:0] num;
        logic                    zero_in;
        logic                    den_zero;
    } t_side;

    typedef logic [EXP_STEPS-1:0][MANT_W-1:0] t_exp_tab;

    function automatic logic [63:0] f_isqrt(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = x;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > v) bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-(k+1)) in Q30, each an integer square root of the one before
    function automatic t_exp_tab f_exp_tab();
        t_exp_tab    tab;
        logic [63:0] c;
        c      = f_isqrt(64'd2 << 60);
        tab[0] = c[MANT_W-1:0];
        for (int k = 1; k < EXP_STEPS; k++) begin
            c      = f_isqrt({33'd0, tab[k-1]} << Q30);
            tab[k] = c[MANT_W-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = f_exp_tab();

endpackage

// ----- design/spi_log2.sv -----
// ----------------------------------------------------------------------------
// spi_log2
// pipelined log2 in Q.16, one squaring per stage, fraction truncated
// ----------------------------------------------------------------------------
module spi_log2 (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [spi_pkg::IN_W-1:0]   i_x,
    output logic [spi_pkg::LOG_W-1:0]  o_log,
    output logic [spi_pkg::IN_W-1:0]   o_x
);

    localparam int N = spi_pkg::LOG_FRAC;

    logic [4:0]                       w_e;
    logic [spi_pkg::MANT_W-1:0]       w_m;
    logic [2*spi_pkg::MANT_W-1:0]     w_sq [N];
    logic [spi_pkg::MANT_W:0]         w_t  [N];

    logic [4:0]                       r_e  [N+1];
    logic [spi_pkg::MANT_W-1:0]       r_m  [N+1];
    logic [N-1:0]                     r_fr [N+1];
    logic [spi_pkg::IN_W-1:0]         r_x  [N+1];

    // leading one and normalisation
    always_comb begin
        w_e = 5'd0;
        for (int i = 0; i < spi_pkg::IN_W; i++) begin
            if (i_x[i]) w_e = 5'(i);
        end
        w_m = {7'd0, i_x} << (5'd30 - w_e);
    end

    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_sq[j] = 62'(r_m[j]) * 62'(r_m[j]);
            w_t[j]  = w_sq[j][61:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0]  <= w_e;
            r_m[0]  <= w_m;
            r_fr[0] <= '0;
            r_x[0]  <= i_x;
            for (int j = 0; j < N; j++) begin
                r_e[j+1]  <= r_e[j];
                r_x[j+1]  <= r_x[j];
                r_fr[j+1] <= {r_fr[j][N-2:0], w_t[j][31]};
                r_m[j+1]  <= w_t[j][31] ? w_t[j][31:1] : w_t[j][30:0];
            end
        end
    end

    assign o_log = {r_e[N], r_fr[N]};
    assign o_x   = r_x[N];

endmodule

// ----- design/spi_div.sv -----
// ----------------------------------------------------------------------------
// spi_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module spi_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [spi_pkg::DVD_W-1:0]   i_dvd,
    input  logic [spi_pkg::DVS_W-1:0]   i_dvs,
    input  logic                        i_neg,
    input  spi_pkg::t_side              i_side,
    output logic [spi_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_ovf,
    output logic                        o_neg,
    output spi_pkg::t_side              o_side
);

    localparam int QW = spi_pkg::QUO_W;
    localparam int CW = spi_pkg::DVS_W + QW + 1;

    logic [CW-1:0]                 w_lim;
    logic [CW-1:0]                 w_sh  [QW];
    logic                          w_ge  [QW];

    logic [spi_pkg::DVD_W-1:0]     r_rem [QW+1];
    logic [spi_pkg::DVS_W-1:0]     r_dvs [QW+1];
    logic [QW-1:0]                 r_quo [QW+1];
    logic                          r_ovf [QW+1];
    logic                          r_neg [QW+1];
    spi_pkg::t_side                r_side[QW+1];

    // quotient needs more than QW bits
    assign w_lim = CW'(i_dvs) << QW;

    always_comb begin
        for (int j = 0; j < QW; j++) begin
            w_sh[j] = CW'(r_dvs[j]) << (QW - 1 - j);
            w_ge[j] = CW'(r_rem[j]) >= w_sh[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_dvd;
            r_dvs[0]  <= i_dvs;
            r_quo[0]  <= '0;
            r_ovf[0]  <= CW'(i_dvd) >= w_lim;
            r_neg[0]  <= i_neg;
            r_side[0] <= i_side;
            for (int j = 0; j < QW; j++) begin
                r_rem[j+1]  <= w_ge[j] ? (r_rem[j] - w_sh[j][spi_pkg::DVD_W-1:0])
                                       : r_rem[j];
                r_quo[j+1]  <= r_quo[j] | (QW'(w_ge[j]) << (QW - 1 - j));
                r_dvs[j+1]  <= r_dvs[j];
                r_ovf[j+1]  <= r_ovf[j];
                r_neg[j+1]  <= r_neg[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_quo  = r_quo[QW];
    assign o_ovf  = r_ovf[QW];
    assign o_neg  = r_neg[QW];
    assign o_side = r_side[QW];

endmodule

// ----- design/spectral_peak_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// spectral_peak_interpolator_top
// quadratic (parabolic / gaussian) interpolation of a spectral peak
// ----------------------------------------------------------------------------
// Takes one word per clock (peak, left and right bin magnitudes) and returns
// one word per clock, both only while the pipeline is not held. The stages,
// in order, are the log2 squaring chain, curvature and operand set-up, the
// restoring divider (one quotient bit a stage), clamping, the offset multiply
// and the amplitude correction, the exp2 constant product and final scaling
// into the output register. The pipeline moves as one; it only holds while a
// finished word waits in the output register and i_stall is high. log_mode
// may be written only while the pipeline is empty; the write port is always
// ready.
// ----------------------------------------------------------------------------
module spectral_peak_interpolator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_log_mode,
    // input words
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [spi_pkg::IN_W-1:0]            i_peak_magnitude,
    input  logic [spi_pkg::IN_W-1:0]            i_left_magnitude,
    input  logic [spi_pkg::IN_W-1:0]            i_right_magnitude,
    // result words
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [spi_pkg::OFF_W-1:0]    o_bin_offset,
    output logic [spi_pkg::AMP_W-1:0]           o_amplitude,
    output logic [1:0]                          o_status
);

    localparam int VW = spi_pkg::VAL_W;
    localparam int DW = spi_pkg::DEN_W;
    localparam int QW = spi_pkg::QUO_W;
    localparam int PW = spi_pkg::PROD_W;
    localparam int YW = spi_pkg::Y_W;
    localparam int NE = spi_pkg::EXP_STEPS;
    localparam int RW = 41;  // rounding / scaling width

    // per-stage payload of the exp2 product chain
    typedef struct packed {
        logic [31:0]                      m;
        logic [spi_pkg::LOG_FRAC-1:0]     f;
        logic signed [spi_pkg::EXP_N_W-1:0] n;
        logic [spi_pkg::AMP_W-1:0]        lin_amp;
        logic signed [spi_pkg::OFF_W-1:0] p;
        logic                             sat;
        logic [spi_pkg::IN_W-1:0]         pk;
        logic                             zero_in;
        logic                             den_zero;
    } t_exp;

    logic                        w_en;
    logic                        r_log_mode;
    logic [spi_pkg::PIPE_LAT-1:0] r_vld;

    // log lanes
    logic [spi_pkg::LOG_W-1:0]   w_la, w_lb, w_lc;
    logic [spi_pkg::IN_W-1:0]    w_xa, w_xb, w_xc;

    // curvature stage
    logic signed [VW-1:0]        w_av, w_bv, w_cv;
    logic signed [VW-1:0]        r_nd_num;
    logic signed [DW-1:0]        r_nd_den;
    spi_pkg::t_side              r_nd_side;

    // divider set-up stage
    logic [VW-2:0]               w_un;
    logic [DW-2:0]               w_ud;
    logic [spi_pkg::DVD_W-1:0]   r_ab_dvd;
    logic [spi_pkg::DVS_W-1:0]   r_ab_dvs;
    logic                        r_ab_neg;
    spi_pkg::t_side              r_ab_side;

    // divider output
    logic [QW-1:0]               w_quo;
    logic                        w_ovf, w_neg;
    spi_pkg::t_side              w_dside;

    // clamp stage
    logic                        w_psat;
    logic signed [QW:0]          w_sq;
    logic signed [spi_pkg::OFF_W-1:0] w_p;
    logic signed [spi_pkg::OFF_W-1:0] r_p_p;
    logic                        r_p_sat;
    spi_pkg::t_side              r_p_side;

    // multiply stage
    logic signed [PW-1:0]        r_mu_t;
    logic signed [spi_pkg::OFF_W-1:0] r_mu_p;
    logic                        r_mu_sat;
    spi_pkg::t_side              r_mu_side;

    // amplitude correction stage
    logic [PW-1:0]               w_ut;
    logic [PW-1:0]               w_r;
    logic signed [YW-1:0]        w_adj;
    logic signed [YW-1:0]        r_y;
    logic signed [spi_pkg::OFF_W-1:0] r_y_p;
    logic                        r_y_sat;
    spi_pkg::t_side              r_y_side;

    // exp2 chain
    t_exp                        w_ex0;
    t_exp                        n_ex  [NE];
    t_exp                        r_ex  [NE];
    logic [62:0]                 w_prod[NE];

    // output stage
    t_exp                        w_last;
    logic signed [spi_pkg::EXP_N_W-1:0] w_sh_s;
    logic [5:0]                  w_sh;
    logic [RW-1:0]               w_rnd;
    logic [RW-1:0]               w_v;
    logic [spi_pkg::AMP_W-1:0]   w_amp_log;
    logic                        w_sat_log;
    logic signed [spi_pkg::OFF_W-1:0] n_bin_offset;
    logic [spi_pkg::AMP_W-1:0]   n_amplitude;
    spi_pkg::t_status            n_status;
    logic signed [spi_pkg::OFF_W-1:0] r_bin_offset;
    logic [spi_pkg::AMP_W-1:0]   r_amplitude;
    spi_pkg::t_status            r_status;

    // whole pipe advances unless a finished word is held back
    assign w_en    = !(r_vld[spi_pkg::PIPE_LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[spi_pkg::PIPE_LAT-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_mode <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (i_cfg_valid) r_log_mode <= i_cfg_log_mode;
            if (w_en) r_vld <= {r_vld[spi_pkg::PIPE_LAT-2:0], i_valid};
        end
    end

    // ---------------------------------------------------------------- log2
    spi_log2 u_log_a (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_left_magnitude),
        .o_log (w_la),  .o_x  (w_xa)
    );
    spi_log2 u_log_b (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_peak_magnitude),
        .o_log (w_lb),  .o_x  (w_xb)
    );
    spi_log2 u_log_c (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_right_magnitude),
        .o_log (w_lc),  .o_x  (w_xc)
    );

    // ---------------------------------------------------------------- curvature
    always_comb begin
        if (r_log_mode) begin
            w_av = VW'(w_la);
            w_bv = VW'(w_lb);
            w_cv = VW'(w_lc);
        end else begin
            w_av = VW'(w_xa);
            w_bv = VW'(w_xb);
            w_cv = VW'(w_xc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nd_num           <= w_av - w_cv;
            r_nd_den           <= DW'(w_av) - (DW'(w_bv) <<< 1) + DW'(w_cv);
            r_nd_side.pk       <= w_xb;
            r_nd_side.b        <= w_bv;
            r_nd_side.num      <= '0;
            r_nd_side.zero_in  <= r_log_mode &&
                                  (w_xa == '0 || w_xb == '0 || w_xc == '0);
            r_nd_side.den_zero <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- divider set-up
    // quotient = (2|num| 2^14 + |den|) / (2|den|), rounds half away from zero
    assign w_un = r_nd_num[VW-1] ? (VW-1)'(-r_nd_num) : r_nd_num[VW-2:0];
    assign w_ud = r_nd_den[DW-1] ? (DW-1)'(-r_nd_den) : r_nd_den[DW-2:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ab_dvd           <= (spi_pkg::DVD_W'(w_un) << spi_pkg::OFF_FRAC)
                                  + spi_pkg::DVD_W'(w_ud);
            r_ab_dvs           <= {w_ud, 1'b0};
            r_ab_neg           <= r_nd_num[VW-1] ^ r_nd_den[DW-1];
            r_ab_side.pk       <= r_nd_side.pk;
            r_ab_side.b        <= r_nd_side.b;
            r_ab_side.zero_in  <= r_nd_side.zero_in;
            r_ab_side.num      <= r_nd_num;
            r_ab_side.den_zero <= (r_nd_den == '0);
        end
    end

    spi_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dvd  (r_ab_dvd),
        .i_dvs  (r_ab_dvs),
        .i_neg  (r_ab_neg),
        .i_side (r_ab_side),
        .o_quo  (w_quo),
        .o_ovf  (w_ovf),
        .o_neg  (w_neg),
        .o_side (w_dside)
    );

    // ---------------------------------------------------------------- offset clamp
    always_comb begin
        w_psat = w_ovf
              || (!w_neg && w_quo > QW'((1 << spi_pkg::OFF_FRAC) - 1))
              || ( w_neg && w_quo > QW'(1 << spi_pkg::OFF_FRAC));
        w_sq   = w_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        if (w_psat) begin
            w_p = w_neg ? {1'b1, {(spi_pkg::OFF_W-1){1'b0}}}
                        : {1'b0, {(spi_pkg::OFF_W-1){1'b1}}};
        end else begin
            w_p = w_sq[spi_pkg::OFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_p    <= w_p;
            r_p_sat  <= w_psat;
            r_p_side <= w_dside;
        end
    end

    // ---------------------------------------------------------------- offset times numerator
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mu_t    <= PW'(r_p_side.num) * PW'(r_p_p);
            r_mu_p    <= r_p_p;
            r_mu_sat  <= r_p_sat;
            r_mu_side <= r_p_side;
        end
    end

    // ---------------------------------------------------------------- y = b - adj
    always_comb begin
        w_ut  = r_mu_t[PW-1] ? PW'(-r_mu_t) : PW'(r_mu_t);
        w_r   = (w_ut + (PW'(1) << (spi_pkg::OFF_FRAC + 1))) >> (spi_pkg::OFF_FRAC + 2);
        w_adj = r_mu_t[PW-1] ? -$signed(w_r[YW-1:0]) : $signed(w_r[YW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y      <= YW'(r_mu_side.b) - w_adj;
            r_y_p    <= r_mu_p;
            r_y_sat  <= r_mu_sat;
            r_y_side <= r_mu_side;
        end
    end

    // ---------------------------------------------------------------- exp2 chain
    // linear-mode clamp rides alongside the product of the selected constants
    always_comb begin
        w_ex0.m        = 32'd1 << spi_pkg::Q30;
        w_ex0.f        = r_y[spi_pkg::LOG_FRAC-1:0];
        w_ex0.n        = r_y[YW-1:spi_pkg::LOG_FRAC];
        w_ex0.p        = r_y_p;
        w_ex0.pk       = r_y_side.pk;
        w_ex0.zero_in  = r_y_side.zero_in;
        w_ex0.den_zero = r_y_side.den_zero;
        w_ex0.sat      = r_y_sat;
        if (r_y < 0) begin
            w_ex0.lin_amp = '0;
            if (!r_log_mode) w_ex0.sat = 1'b1;
        end else if (r_y > YW'(spi_pkg::AMP_MAX)) begin
            w_ex0.lin_amp = spi_pkg::AMP_MAX;
            if (!r_log_mode) w_ex0.sat = 1'b1;
        end else begin
            w_ex0.lin_amp = r_y[spi_pkg::AMP_W-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            n_ex[k]   = (k == 0) ? w_ex0 : r_ex[(k == 0) ? 0 : k-1];
            w_prod[k] = 63'(n_ex[k].m) * 63'(spi_pkg::EXP_TAB[k]);
            if (n_ex[k].f[spi_pkg::LOG_FRAC-1-k]) n_ex[k].m = w_prod[k][61:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NE; k++) r_ex[k] <= n_ex[k];
        end
    end

    // ---------------------------------------------------------------- scaling and result
    always_comb begin
        w_last    = r_ex[NE-1];
        w_sh_s    = spi_pkg::EXP_N_W'(spi_pkg::Q30) - w_last.n;
        w_sh      = w_sh_s[5:0];
        w_rnd     = RW'(w_last.m) + (RW'(1) << (w_sh - 6'd1));
        w_v       = w_rnd >> w_sh;
        w_amp_log = '0;
        w_sat_log = 1'b0;
        if (w_last.n >= spi_pkg::EXP_N_W'(spi_pkg::AMP_W)) begin
            w_amp_log = spi_pkg::AMP_MAX;
            w_sat_log = 1'b1;
        end else if (w_last.n < -spi_pkg::EXP_N_W'(10)) begin
            w_amp_log = '0;
        end else if (w_v > RW'(spi_pkg::AMP_MAX)) begin
            w_amp_log = spi_pkg::AMP_MAX;
            w_sat_log = 1'b1;
        end else begin
            w_amp_log = w_v[spi_pkg::AMP_W-1:0];
        end

        priority if (w_last.zero_in) begin
            n_status     = spi_pkg::ST_ZERO_IN;
            n_bin_offset = '0;
            n_amplitude  = spi_pkg::AMP_W'(w_last.pk);
        end else if (w_last.den_zero) begin
            n_status     = spi_pkg::ST_ZERO_CURV;
            n_bin_offset = '0;
            n_amplitude  = spi_pkg::AMP_W'(w_last.pk);
        end else begin
            n_bin_offset = w_last.p;
            n_amplitude  = r_log_mode ? w_amp_log : w_last.lin_amp;
            n_status     = (w_last.sat || (r_log_mode && w_sat_log))
                           ? spi_pkg::ST_SAT : spi_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bin_offset <= n_bin_offset;
            r_amplitude  <= n_amplitude;
            r_status     <= n_status;
        end
    end

    assign o_bin_offset = r_bin_offset;
    assign o_amplitude  = r_amplitude;
    assign o_status     = r_status;

endmodule
